// ===== rtl/amvc_pkg.sv =====
// shared codes and lookup tables for the address multiplexer and video counter
`default_nettype none
package amvc_pkg;

	// opcodes of an input beat
	localparam logic [2:0] OP_READ    = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_FETCH   = 3'd2;
	localparam logic [2:0] OP_ADVANCE = 3'd3;
	localparam logic [2:0] OP_HSYNC   = 3'd4;
	localparam logic [2:0] OP_FSYNC   = 3'd5;

	// target codes of a result beat
	localparam logic [3:0] TGT_NONE    = 4'd0;
	localparam logic [3:0] TGT_RAM     = 4'd1;
	localparam logic [3:0] TGT_BASIC   = 4'd2;
	localparam logic [3:0] TGT_EXT     = 4'd3;
	localparam logic [3:0] TGT_CART    = 4'd4;
	localparam logic [3:0] TGT_DISK    = 4'd5;
	localparam logic [3:0] TGT_PIA1    = 4'd6;
	localparam logic [3:0] TGT_PIA2    = 4'd7;
	localparam logic [3:0] TGT_CARTIO  = 4'd8;
	localparam logic [3:0] TGT_CONTROL = 4'd9;

	// rom_present bit positions
	localparam int ROM_BASIC = 0;
	localparam int ROM_EXT   = 1;
	localparam int ROM_CART  = 2;
	localparam int ROM_DISK  = 3;

	// control word fields
	localparam int CTL_PAGE = 10;
	localparam int CTL_TY   = 15;
	localparam logic [2:0] MODE_NO_SYNC_CLEAR = 3'd7;

	// column pass count per video mode
	function automatic logic [1:0] mult_x(input logic [2:0] mode);
		logic [1:0] m;
		unique case (mode)
			3'd1: m = 2'd3;
			3'd3: m = 2'd2;
			default: m = 2'd1;
		endcase
		return m;
	endfunction

	// row pass count per video mode
	function automatic logic [3:0] mult_y(input logic [2:0] mode);
		logic [3:0] m;
		unique case (mode)
			3'd0: m = 4'd12;
			3'd2: m = 4'd3;
			3'd4: m = 4'd2;
			default: m = 4'd1;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/amvc_if.sv =====
// handshake channels for input beats and result beats
`default_nettype none
interface amvc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, opcode, address, write_data, input ready);
	modport sink   (input valid, opcode, address, write_data, output ready);
endinterface

interface amvc_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  target;
	logic [15:0] mapped_address;
	logic [15:0] control_word;

	modport source (output valid, target, mapped_address, control_word, input ready);
	modport sink   (input valid, target, mapped_address, control_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/address_multiplexer_video_counter.sv =====
// address decode, control bits and video address counter, top level
//
//  channel  | dir | payload                                   | handshake
//  req      | in  | opcode, address, write_data               | valid / ready
//  rsp      | out | target, mapped_address, control_word      | valid / ready
//  cfg      | in  | cfg_wdata (rom_present)                   | cfg_we, no wait
//
// a beat is registered in the input stage, decoded combinationally and lands
// in the result register; the flow sustains one beat per cycle while rsp is
// taken. state (control bits, counters, video base) updates at the edge
// the result is loaded, so a following beat sees it. a stalled result holds
// the input stage; req.ready drops only when both stages are full and rsp
// is not taken. arst_n clears valid flags, control bits, counters and rom_present.
`default_nettype none
module address_multiplexer_video_counter (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata,
	amvc_req_if.sink        req,
	amvc_rsp_if.source      rsp
);
	import amvc_pkg::*;

	logic        valid_s1;
	logic [2:0]  opcode_s1;
	logic [15:0] address_s1;

	logic        rsp_valid_q;
	logic [3:0]  target_q;
	logic [15:0] maddr_q;

	logic [3:0]  rom_present_q;
	logic [15:0] ctrl_q;
	logic [5:0]  col_q;
	logic [8:0]  row_q;
	logic [15:0] base_q;

	logic        advance;
	logic [3:0]  target_d;
	logic [15:0] maddr_d;
	logic [15:0] ctrl_d;
	logic [5:0]  col_d;
	logic [8:0]  row_d;
	logic [15:0] base_d;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	assign rsp.valid          = rsp_valid_q;
	assign rsp.target         = target_q;
	assign rsp.mapped_address = maddr_q;
	assign rsp.control_word   = ctrl_q;

	always_comb begin
		logic        is_wr;
		logic        ty;
		logic [15:0] a;
		logic [2:0]  mode;
		logic [5:0]  col_inc;
		logic [8:0]  row_mid;
		is_wr    = (opcode_s1 == OP_WRITE);
		ty       = ctrl_q[CTL_TY];
		a        = address_s1;
		mode     = ctrl_q[2:0];
		target_d = TGT_NONE;
		maddr_d  = 16'h0000;
		ctrl_d   = ctrl_q;
		col_d    = col_q;
		row_d    = row_q;
		base_d   = base_q;
		col_inc  = col_q + 6'd1;
		row_mid  = row_q;

		unique case (opcode_s1)
			OP_READ, OP_WRITE: begin
				if (!ty && a <= 16'h7fff) begin
					target_d = TGT_RAM;
					maddr_d  = {ctrl_q[CTL_PAGE] | a[15], a[14:0]};
				end else if (a <= 16'hfeff) begin
					if (ty) begin
						target_d = TGT_RAM;
						maddr_d  = a;
					end else if (is_wr) begin
						target_d = TGT_NONE;
					end else if (a <= 16'h9fff) begin
						if (rom_present_q[ROM_BASIC]) begin
							target_d = TGT_BASIC;
							maddr_d  = {3'b000, a[12:0]};
						end
					end else if (a <= 16'hbfff) begin
						if (rom_present_q[ROM_EXT]) begin
							target_d = TGT_EXT;
							maddr_d  = {3'b000, a[12:0]};
						end
					end else if (rom_present_q[ROM_CART]) begin
						target_d = TGT_CART;
						maddr_d  = {2'b00, a[13:0]};
					end else if (rom_present_q[ROM_DISK]) begin
						target_d = TGT_DISK;
						maddr_d  = {2'b00, a[13:0]};
					end
				end else if (a <= 16'hff1f) begin
					target_d = TGT_PIA1;
					maddr_d  = {11'd0, a[4:0]};
				end else if (a <= 16'hff3f) begin
					target_d = TGT_PIA2;
					maddr_d  = {11'd0, a[4:0]};
				end else if (a <= 16'hff5f) begin
					target_d = TGT_CARTIO;
					maddr_d  = {11'd0, a[4:0]};
				end else if (is_wr) begin
					if (a >= 16'hffc0 && a <= 16'hffdf) begin
						target_d = TGT_CONTROL;
						maddr_d  = {11'd0, a[4:0]};
						// odd address sets, even clears the bit at a[4:1]
						ctrl_d[a[4:1]] = a[0];
					end
				end else if (a >= 16'hffe0 && rom_present_q[ROM_EXT]) begin
					target_d = TGT_EXT;
					maddr_d  = {3'b000, a[12:0]};
				end
			end
			OP_FETCH: begin
				target_d = TGT_RAM;
				maddr_d  = {base_q[15:5], row_q[4], col_q[3:0]};
			end
			OP_ADVANCE: begin
				col_d = col_inc;
				if (col_inc[5:4] >= mult_x(mode)) begin
					col_d   = 6'd0;
					row_mid = row_q + 9'd16;
				end
				row_d = row_mid;
				if (row_mid[8:5] >= mult_y(mode)) begin
					row_d  = 9'd0;
					base_d = base_q + 16'd32;
				end
			end
			OP_HSYNC: begin
				if (mode != MODE_NO_SYNC_CLEAR) begin
					col_d = {col_q[5:4], 4'd0};
					if (!ctrl_q[0]) row_d = {row_q[8:5], 5'd0};
				end
			end
			OP_FSYNC: begin
				col_d  = 6'd0;
				row_d  = 9'd0;
				base_d = {ctrl_q[9:3], 9'd0};
			end
			default: begin
			end
		endcase

		// counter steps report the video address after the step
		if (opcode_s1 == OP_ADVANCE || opcode_s1 == OP_HSYNC || opcode_s1 == OP_FSYNC)
			maddr_d = {base_d[15:5], row_d[4], col_d[3:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			rsp_valid_q   <= 1'b0;
			rom_present_q <= 4'd0;
			ctrl_q        <= 16'd0;
			col_q         <= 6'd0;
			row_q         <= 9'd0;
			base_q        <= 16'd0;
		end else begin
			if (cfg_we) rom_present_q <= cfg_wdata;
			if (req.ready) valid_s1 <= req.valid;
			if (advance) begin
				rsp_valid_q <= 1'b1;
				ctrl_q      <= ctrl_d;
				col_q       <= col_d;
				row_q       <= row_d;
				base_q      <= base_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			opcode_s1  <= req.opcode;
			address_s1 <= req.address;
		end
		if (advance) begin
			target_q <= target_d;
			maddr_q  <= maddr_d;
		end
	end

	// a stalled result freezes all counter and control state
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |=>
			$stable(ctrl_q) && $stable(col_q) && $stable(row_q) && $stable(base_q))
		else $error("state changed while result stalled");

	// control bits move only on a control window write
	a_ctrl_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && target_d == TGT_CONTROL) |=> $stable(ctrl_q))
		else $error("control bits changed without control write");

	// a video fetch always goes to ram
	a_fetch_to_ram: assert property (@(posedge clk) disable iff (!arst_n)
		advance && opcode_s1 == OP_FETCH |=> rsp_valid_q && target_q == TGT_RAM)
		else $error("video fetch not routed to ram");

endmodule
`default_nettype wire

// ===== tb/sv/address_multiplexer_video_counter_tb.sv =====
// self-checking testbench for the address multiplexer and video counter
`timescale 1ns / 1ps
module address_multiplexer_video_counter_tb;
	import amvc_pkg::*;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int RESET_CYCLES = 10;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_BEATS  = 300;
	localparam int N_DIR        = 26;

	typedef struct packed {
		logic [3:0]  target;
		logic [15:0] maddr;
		logic [15:0] ctl;
	} bus_result_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] addr;
		logic [7:0]  wd;
		logic [3:0]  rom;
		logic        typed;
		bus_result_t result;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [3:0] cfg_wdata;

	amvc_req_if req_ch ();
	amvc_rsp_if rsp_ch ();

	address_multiplexer_video_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// predictor state
	logic [15:0] ctl_m;
	logic [5:0]  col_m;
	logic [8:0]  row_m;
	logic [15:0] base_m;
	logic [3:0]  rom_m;

	bus_result_t expected_beats [$];
	int err_count;
	int beats_sent;
	int results_checked;
	int rom_writes;
	int src_idle_pct;
	int snk_idle_pct;
	int stall_cycles;

	// typed rows are read straight off the decode map
	dir_row_t dir_rows [N_DIR] = '{
		'{OP_READ,    16'h0000, 8'h00, 4'h0, 1'b1, '{TGT_RAM,     16'h0000, 16'h0000}},
		'{OP_READ,    16'h7fff, 8'hff, 4'h0, 1'b1, '{TGT_RAM,     16'h7fff, 16'h0000}},
		'{OP_READ,    16'h8000, 8'h00, 4'h0, 1'b1, '{TGT_NONE,    16'h0000, 16'h0000}},
		'{OP_READ,    16'hffff, 8'hff, 4'h0, 1'b1, '{TGT_NONE,    16'h0000, 16'h0000}},
		'{OP_READ,    16'hff00, 8'h00, 4'h0, 1'b1, '{TGT_PIA1,    16'h0000, 16'h0000}},
		'{OP_WRITE,   16'hff3f, 8'hff, 4'h0, 1'b1, '{TGT_PIA2,    16'h001f, 16'h0000}},
		'{OP_READ,    16'hff5f, 8'h00, 4'h0, 1'b1, '{TGT_CARTIO,  16'h001f, 16'h0000}},
		'{OP_WRITE,   16'hff60, 8'h5a, 4'h0, 1'b1, '{TGT_NONE,    16'h0000, 16'h0000}},
		'{OP_WRITE,   16'h9000, 8'ha5, 4'h0, 1'b1, '{TGT_NONE,    16'h0000, 16'h0000}},
		'{OP_FETCH,   16'h0000, 8'h00, 4'h0, 1'b1, '{TGT_RAM,     16'h0000, 16'h0000}},
		'{OP_SPARE6,  16'hffff, 8'hff, 4'h0, 1'b1, '{TGT_NONE,    16'h0000, 16'h0000}},
		'{OP_WRITE,   16'hffd5, 8'h00, 4'h0, 1'b1, '{TGT_CONTROL, 16'h0015, 16'h0400}},
		'{OP_READ,    16'h1234, 8'h00, 4'h0, 1'b1, '{TGT_RAM,     16'h9234, 16'h0400}},
		'{OP_WRITE,   16'h0000, 8'hff, 4'h0, 1'b1, '{TGT_RAM,     16'h8000, 16'h0400}},
		'{OP_WRITE,   16'hffd4, 8'h00, 4'h0, 1'b1, '{TGT_CONTROL, 16'h0014, 16'h0000}},
		'{OP_READ,    16'h8000, 8'h00, 4'hf, 1'b1, '{TGT_BASIC,   16'h0000, 16'h0000}},
		'{OP_READ,    16'ha000, 8'h00, 4'hf, 1'b1, '{TGT_EXT,     16'h0000, 16'h0000}},
		'{OP_READ,    16'hfeff, 8'h00, 4'hf, 1'b1, '{TGT_CART,    16'h3eff, 16'h0000}},
		'{OP_READ,    16'hffe0, 8'h00, 4'hf, 1'b1, '{TGT_EXT,     16'h1fe0, 16'h0000}},
		'{OP_READ,    16'hffc0, 8'h00, 4'hf, 1'b1, '{TGT_NONE,    16'h0000, 16'h0000}},
		'{OP_READ,    16'hc000, 8'h00, 4'h8, 1'b1, '{TGT_DISK,    16'h0000, 16'h0000}},
		'{OP_WRITE,   16'hffdf, 8'h00, 4'h8, 1'b1, '{TGT_CONTROL, 16'h001f, 16'h8000}},
		'{OP_READ,    16'h9000, 8'h00, 4'h8, 1'b1, '{TGT_RAM,     16'h9000, 16'h8000}},
		'{OP_WRITE,   16'hffde, 8'h00, 4'h8, 1'b0, '{TGT_NONE,    16'h0000, 16'h0000}},
		'{OP_ADVANCE, 16'h0000, 8'h00, 4'h8, 1'b0, '{TGT_NONE,    16'h0000, 16'h0000}},
		'{OP_FSYNC,   16'hffff, 8'h00, 4'h8, 1'b0, '{TGT_NONE,    16'h0000, 16'h0000}}
	};

	logic [15:0] edge_addrs [20] = '{
		16'h0000, 16'h7fff, 16'h8000, 16'h9fff, 16'ha000, 16'hbfff, 16'hc000,
		16'hfeff, 16'hff00, 16'hff1f, 16'hff20, 16'hff3f, 16'hff40, 16'hff5f,
		16'hff60, 16'hffbf, 16'hffc0, 16'hffdf, 16'hffe0, 16'hffff
	};

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [15:0] video_addr_m();
		return {base_m[15:5], row_m[4], col_m[3:0]};
	endfunction

	function automatic logic [3:0] decode_cpu_m(input logic [15:0] a, input logic wr,
			output logic [15:0] ma);
		logic [3:0] t;
		t = TGT_NONE;
		ma = 16'h0000;
		if (!ctl_m[CTL_TY] && a <= 16'h7fff) begin
			t = TGT_RAM;
			ma = a | (ctl_m[CTL_PAGE] ? 16'h8000 : 16'h0000);
		end else if (!ctl_m[CTL_TY] && a <= 16'hfeff) begin
			// rom area, writes fall on open bus
			if (wr) begin
				t = TGT_NONE;
			end else if (a <= 16'h9fff) begin
				if (rom_m[ROM_BASIC]) begin
					t = TGT_BASIC;
					ma = a & 16'h1fff;
				end
			end else if (a <= 16'hbfff) begin
				if (rom_m[ROM_EXT]) begin
					t = TGT_EXT;
					ma = a & 16'h1fff;
				end
			end else if (rom_m[ROM_CART]) begin
				t = TGT_CART;
				ma = a & 16'h3fff;
			end else if (rom_m[ROM_DISK]) begin
				t = TGT_DISK;
				ma = a & 16'h3fff;
			end
		end else if (ctl_m[CTL_TY] && a <= 16'hfeff) begin
			t = TGT_RAM;
			ma = a;
		end else if (a <= 16'hff1f) begin
			t = TGT_PIA1;
			ma = a & 16'h001f;
		end else if (a <= 16'hff3f) begin
			t = TGT_PIA2;
			ma = a & 16'h001f;
		end else if (a <= 16'hff5f) begin
			t = TGT_CARTIO;
			ma = a & 16'h001f;
		end else if (wr) begin
			if (a >= 16'hffc0 && a <= 16'hffdf) begin
				t = TGT_CONTROL;
				ma = a & 16'h001f;
			end
		end else if (a >= 16'hffe0 && rom_m[ROM_EXT]) begin
			t = TGT_EXT;
			ma = a & 16'h1fff;
		end
		return t;
	endfunction

	function automatic bus_result_t predict_bus_beat(input logic [2:0] op,
			input logic [15:0] a);
		bus_result_t res;
		logic [1:0] xpass;
		logic [3:0] ypass;
		logic [15:0] ma;
		res.target = TGT_NONE;
		res.maddr = 16'h0000;
		case (op)
			OP_READ: begin
				res.target = decode_cpu_m(a, 1'b0, ma);
				res.maddr = ma;
			end
			OP_WRITE: begin
				res.target = decode_cpu_m(a, 1'b1, ma);
				res.maddr = ma;
				if (res.target == TGT_CONTROL)
					ctl_m[a[4:1]] = a[0];
			end
			OP_FETCH: begin
				res.target = TGT_RAM;
				res.maddr = video_addr_m();
			end
			OP_ADVANCE: begin
				case (ctl_m[2:0])
					3'd1: xpass = 2'd3;
					3'd3: xpass = 2'd2;
					default: xpass = 2'd1;
				endcase
				case (ctl_m[2:0])
					3'd0: ypass = 4'd12;
					3'd2: ypass = 4'd3;
					3'd4: ypass = 4'd2;
					default: ypass = 4'd1;
				endcase
				col_m = col_m + 6'd1;
				if (col_m[5:4] >= xpass) begin
					row_m = row_m + 9'd16;
					col_m = 6'd0;
				end
				if (row_m[8:5] >= ypass) begin
					base_m = base_m + 16'd32;
					row_m = 9'd0;
				end
				res.maddr = video_addr_m();
			end
			OP_HSYNC: begin
				if (ctl_m[2:0] != MODE_NO_SYNC_CLEAR) begin
					col_m[3:0] = 4'd0;
					if (!ctl_m[0])
						row_m[4:0] = 5'd0;
				end
				res.maddr = video_addr_m();
			end
			OP_FSYNC: begin
				col_m = 6'd0;
				row_m = 9'd0;
				base_m = {ctl_m[9:3], 9'd0};
				res.maddr = video_addr_m();
			end
			default: begin
			end
		endcase
		res.ctl = ctl_m;
		return res;
	endfunction

	function automatic logic [15:0] pick_address();
		logic [15:0] a;
		case ($urandom_range(0, 3))
			0: a = 16'($urandom);
			1: a = edge_addrs[$urandom_range(0, 19)];
			2: a = {8'hff, 8'($urandom)};
			default: a = {1'b1, 15'($urandom)};
		endcase
		return a;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		$display("%0t: %s: expected %h got %h", $time, what, want, got);
		err_count++;
	endtask

	task automatic send_beat(input logic [2:0] op, input logic [15:0] a, input logic [7:0] wd,
			input logic typed, input bus_result_t typed_result);
		bus_result_t pred;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.address    <= a;
		req_ch.write_data <= wd;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pred = predict_bus_beat(op, a);
		expected_beats.push_back(typed ? typed_result : pred);
		beats_sent++;
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_rom_present(input logic [3:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		rom_m = value;
		cfg_we <= 1'b0;
		rom_writes++;
	endtask

	// receiver side stalls
	always @(posedge clk)
		rsp_ch.ready <= arst_n && ($urandom_range(0, 99) >= snk_idle_pct);

	always @(posedge clk) begin
		bus_result_t got;
		bus_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.target, rsp_ch.mapped_address, rsp_ch.control_word};
			results_checked++;
			if (expected_beats.size() == 0) begin
				report_mismatch("result beat with nothing expected", 16'h0, got.maddr);
			end else begin
				want = expected_beats.pop_front();
				if (got.target !== want.target)
					report_mismatch("target", 16'(want.target), 16'(got.target));
				if (got.maddr !== want.maddr)
					report_mismatch("mapped_address", want.maddr, got.maddr);
				if (got.ctl !== want.ctl)
					report_mismatch("control_word", want.ctl, got.ctl);
			end
		end
	end

	// watchdog on cycles without any beat moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", stall_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int r;
		logic [2:0] op;
		logic [15:0] a;
		int src_mix [3];
		int snk_mix [3];
		logic [3:0] rom_mix [3];
		bus_result_t lost;

		src_mix = '{13, 81, 0};
		snk_mix = '{81, 13, 0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 4'h0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_READ;
		req_ch.address = 16'h0000;
		req_ch.write_data = 8'h00;
		rsp_ch.ready = 1'b0;
		ctl_m = 16'h0000;
		col_m = 6'd0;
		row_m = 9'd0;
		base_m = 16'h0000;
		rom_m = 4'h0;
		err_count = 0;
		beats_sent = 0;
		results_checked = 0;
		rom_writes = 0;
		stall_cycles = 0;
		src_idle_pct = src_mix[0];
		snk_idle_pct = snk_mix[0];
		rom_mix = '{4'hf, 4'h0, 4'($urandom)};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].rom != rom_m)
				write_rom_present(dir_rows[i].rom);
			send_beat(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].wd,
				dir_rows[i].typed, dir_rows[i].result);
		end

		for (int ph = 0; ph < 3; ph++) begin
			write_rom_present(rom_mix[ph]);
			src_idle_pct = src_mix[ph];
			snk_idle_pct = snk_mix[ph];
			for (int i = 0; i < PHASE_BEATS; i++) begin
				// mid-phase: hold off until drained, then a new rom setting
				if (i == PHASE_BEATS / 2)
					write_rom_present(4'($urandom));
				else if ($urandom_range(0, 199) == 0)
					wait_drained();
				r = $urandom_range(0, 99);
				a = 16'($urandom);
				if (r < 30) begin
					op = OP_ADVANCE;
				end else if (r < 40) begin
					op = OP_FETCH;
				end else if (r < 55) begin
					op = OP_WRITE;
					a = 16'hffc0 | 16'($urandom_range(0, 31));
				end else if (r < 80) begin
					op = OP_READ;
					a = pick_address();
				end else if (r < 90) begin
					op = OP_WRITE;
					a = pick_address();
				end else if (r < 94) begin
					op = OP_HSYNC;
				end else if (r < 97) begin
					op = OP_FSYNC;
				end else begin
					op = ($urandom_range(0, 1) != 0) ? OP_SPARE7 : OP_SPARE6;
				end
				send_beat(op, a, 8'($urandom), 1'b0, '0);
			end
		end

		req_ch.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		while (expected_beats.size() != 0) begin
			lost = expected_beats.pop_front();
			report_mismatch("result beat never arrived", lost.maddr, 16'h0);
		end

		$display("covered %0d input beats (%0d from the table), %0d results, %0d rom writes",
			beats_sent, N_DIR, results_checked, rom_writes);
		$display("idle mixes 13/81, 81/13 and none; last video base %h", base_m);
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/amvc_pkg.sv
rtl/amvc_if.sv
rtl/address_multiplexer_video_counter.sv
tb/sv/address_multiplexer_video_counter_tb.sv
